// ===== src/assert_macros.svh =====
// assertion macros used by the rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lsq_pkg.sv =====
// shared constants for the largest square of ones block
// no dependencies
package lsq_pkg;

	localparam int FIELD_W = 13;
	localparam int CFG_IDX_W = 4;
	localparam int DEF_MAX_ROWS = 4096;
	localparam int DEF_MAX_COLS = 4096;

	localparam logic [FIELD_W-1:0] SIZE_RESET = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 4'd1;

endpackage

// ===== src/largest_square_of_ones.sv =====
// largest all-ones square over a row-major binary image; uses lsq_pkg and assert_macros.svh
// one cell item per cycle unless cell_stall is high: an input register stage reads the
// line buffer, one stage computes min-of-three and writes it back; the line buffer has one
// read and one write port per cycle; the result is registered after the frame's last cell
// reset clears counters, best square and output valid, and sets both sizes to 4096;
// the line buffer is not cleared, the first row of every frame reads zero above
module largest_square_of_ones #(
	parameter int MAX_ROWS = lsq_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lsq_pkg::DEF_MAX_COLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic                          cell_req,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [lsq_pkg::FIELD_W-1:0]   side_length,
	output logic [lsq_pkg::FIELD_W-1:0]   top_row,
	output logic [lsq_pkg::FIELD_W-1:0]   left_col,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsq_pkg::FIELD_W-1:0]   cfg_data
);

	`include "assert_macros.svh"

	localparam int FW  = lsq_pkg::FIELD_W;
	localparam int CAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int SW  = CNW;

	// configuration
	logic [FW-1:0] num_rows_q, num_cols_q;
	logic          cfg_wr, cfg_restart;

	// input side position
	logic [CAW-1:0] col_q;
	logic [RAW-1:0] row_q;
	logic [CNW-1:0] cols_eff;
	logic [RNW-1:0] rows_eff;
	logic           col_last, row_last, accept;

	// stage 1
	logic           valid_s1, cell_s1, first_col_s1, row0_s1, last_s1;
	logic [CAW-1:0] col_s1;
	logic [RAW-1:0] row_s1;
	logic [SW-1:0]  up_raw_s1;
	logic           hold_s1, fire_s1;
	logic [SW-1:0]  up, left_v, diag_v, min_ld, min3, cur;

	// line buffer and neighbors
	logic [SW-1:0] line_mem [MAX_COLS];
	logic [SW-1:0] left_q, diag_q;

	// best square
	logic [SW-1:0]  best_side_q, best_side_n;
	logic [RNW-1:0] best_row_q, best_row_n;
	logic [CNW-1:0] best_col_q, best_col_n;

	// output register
	logic          out_valid_q;
	logic [FW-1:0] out_side_q, out_row_q, out_col_q;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_wr
		&& (cfg_index == lsq_pkg::REG_NUM_ROWS || cfg_index == lsq_pkg::REG_NUM_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= lsq_pkg::SIZE_RESET;
			num_cols_q <= lsq_pkg::SIZE_RESET;
		end else if (cfg_wr) begin
			case (cfg_index)
				lsq_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
				lsq_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp sizes to 1..max
	always_comb begin
		if (num_cols_q == '0)
			cols_eff = CNW'(1);
		else if (32'(num_cols_q) > 32'(MAX_COLS))
			cols_eff = CNW'(MAX_COLS);
		else
			cols_eff = CNW'(num_cols_q);
		if (num_rows_q == '0)
			rows_eff = RNW'(1);
		else if (32'(num_rows_q) > 32'(MAX_ROWS))
			rows_eff = RNW'(MAX_ROWS);
		else
			rows_eff = RNW'(num_rows_q);
	end

	assign col_last = (col_q == CAW'(cols_eff - CNW'(1)));
	assign row_last = (row_q == RAW'(rows_eff - RNW'(1)));

	assign hold_s1    = valid_s1 && last_s1 && out_valid_q && result_stall;
	assign fire_s1    = valid_s1 && !hold_s1;
	assign cell_stall = hold_s1;
	assign accept     = cell_valid && !cell_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RAW'(1);
			end else begin
				col_q <= col_q + CAW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1      <= cell_req;
			col_s1       <= col_q;
			row_s1       <= row_q;
			first_col_s1 <= (col_q == '0);
			row0_s1      <= (row_q == '0);
			last_s1      <= col_last && row_last;
		end
	end

	// line buffer, forwarding the write of the same column
	always_ff @(posedge clk) begin
		if (fire_s1)
			line_mem[col_s1] <= cur;
		if (accept) begin
			if (fire_s1 && col_s1 == col_q)
				up_raw_s1 <= cur;
			else
				up_raw_s1 <= line_mem[col_q];
		end
	end

	always_comb begin
		up     = row0_s1 ? '0 : up_raw_s1;
		left_v = first_col_s1 ? '0 : left_q;
		diag_v = first_col_s1 ? '0 : diag_q;
		min_ld = (left_v < diag_v) ? left_v : diag_v;
		min3   = (up < min_ld) ? up : min_ld;
		cur    = cell_s1 ? min3 + SW'(1) : '0;
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			left_q <= cur;
			diag_q <= up;
		end
	end

	always_comb begin
		best_side_n = best_side_q;
		best_row_n  = best_row_q;
		best_col_n  = best_col_q;
		if (cur > best_side_q) begin
			best_side_n = cur;
			best_row_n  = RNW'(32'(row_s1) + 32'd2 - 32'(cur));
			best_col_n  = CNW'(32'(col_s1) + 32'd2 - 32'(cur));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				best_side_q <= '0;
				best_row_q  <= '0;
				best_col_q  <= '0;
			end else begin
				best_side_q <= best_side_n;
				best_row_q  <= best_row_n;
				best_col_q  <= best_col_n;
			end
		end else if (cfg_restart) begin
			best_side_q <= '0;
			best_row_q  <= '0;
			best_col_q  <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			out_side_q <= FW'(best_side_n);
			out_row_q  <= FW'(best_row_n);
			out_col_q  <= FW'(best_col_n);
		end
	end

	assign result_valid = out_valid_q;
	assign side_length  = out_side_q;
	assign top_row      = out_row_q;
	assign left_col     = out_col_q;

	`ASSERT_NEXT(a_last_gives_result, fire_s1 && last_s1, result_valid, "frame end lost its result")
	`ASSERT_SAME(a_stall_only_on_end, cell_stall, valid_s1 && last_s1 && out_valid_q, "bad stall")
	`ASSERT_SAME(a_side_fits_col, fire_s1, 32'(cur) <= 32'(col_s1) + 32'd1, "side exceeds column")
	`ASSERT_SAME(a_best_pos_set, best_side_q != '0, best_row_q != '0 && best_col_q != '0, "bad corner")

endmodule

// ===== tb/largest_square_of_ones_test.sv =====
`timescale 1ns / 100ps
// testbench for largest_square_of_ones: streams binary frames under random idling and
// checks each reported square against a model of the dynamic programming kept here
// depends on lsq_pkg and the largest_square_of_ones rtl
module largest_square_of_ones_test;

	localparam int FIELD_W = lsq_pkg::FIELD_W;
	localparam int CFG_IDX_W = lsq_pkg::CFG_IDX_W;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD = 400;
	localparam int RANDOM_ITEMS = 850;
	localparam int PARTIAL_ITEMS = 200;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 4'd15;

	typedef struct packed {
		logic [FIELD_W-1:0] side;
		logic [FIELD_W-1:0] row;
		logic [FIELD_W-1:0] col;
	} square_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cell_valid = 1'b0;
	logic cell_stall;
	logic cell_req = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [FIELD_W-1:0] side_length;
	logic [FIELD_W-1:0] top_row;
	logic [FIELD_W-1:0] left_col;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FIELD_W-1:0] cfg_data = '0;

	// model of the block
	int unsigned frame_rows = lsq_pkg::DEF_MAX_ROWS;
	int unsigned frame_cols = lsq_pkg::DEF_MAX_COLS;
	int unsigned sides_above [lsq_pkg::DEF_MAX_COLS];
	int unsigned side_left = 0;
	int unsigned side_diag = 0;
	int unsigned pos_row = 0;
	int unsigned pos_col = 0;
	int unsigned lead_side = 0;
	int unsigned lead_row = 0;
	int unsigned lead_col = 0;
	square_t expected_squares [$];

	int errors = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;
	bit hold_long = 1'b0;

	largest_square_of_ones i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_req(cell_req),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.side_length(side_length),
		.top_row(top_row),
		.left_col(left_col),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic int unsigned effective_size(input int unsigned value,
			input int unsigned limit);
		if (value == 0)
			return 1;
		if (value > limit)
			return limit;
		return value;
	endfunction

	function automatic void clear_frame_progress();
		side_left = 0;
		side_diag = 0;
		pos_row = 0;
		pos_col = 0;
		lead_side = 0;
		lead_row = 0;
		lead_col = 0;
	endfunction

	function automatic void advance_square(input bit pixel);
		int unsigned rows;
		int unsigned cols;
		int unsigned up;
		int unsigned low;
		int unsigned cur;
		square_t sq;
		rows = effective_size(frame_rows, lsq_pkg::DEF_MAX_ROWS);
		cols = effective_size(frame_cols, lsq_pkg::DEF_MAX_COLS);
		if (pos_row >= rows || pos_col >= cols)
			clear_frame_progress();
		if (pos_col == 0) begin
			side_left = 0;
			side_diag = 0;
		end
		up = (pos_row > 0) ? sides_above[pos_col] : 0;
		low = (up < side_left) ? up : side_left;
		if (side_diag < low)
			low = side_diag;
		cur = pixel ? low + 1 : 0;
		side_diag = up;
		side_left = cur;
		sides_above[pos_col] = cur;
		if (cur > lead_side) begin
			lead_side = cur;
			lead_row = pos_row + 2 - cur;
			lead_col = pos_col + 2 - cur;
		end
		pos_col++;
		if (pos_col < cols)
			return;
		pos_col = 0;
		pos_row++;
		if (pos_row < rows)
			return;
		sq.side = FIELD_W'(lead_side);
		sq.row = FIELD_W'(lead_row);
		sq.col = FIELD_W'(lead_col);
		expected_squares.push_back(sq);
		clear_frame_progress();
	endfunction

	task automatic send_cell(input bit pixel);
		int gap;
		gap = steady ? 0 : $urandom_range(13);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_req <= pixel;
		do @(posedge clk); while (cell_stall);
		advance_square(pixel);
	endtask

	task automatic send_frame(input int unsigned cells, input int unsigned ones_pct);
		repeat (cells) send_cell($urandom_range(99) < ones_pct);
	endtask

	// no item in flight and no square outstanding
	task automatic settle();
		cell_valid <= 1'b0;
		while (expected_squares.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= FIELD_W'(value);
		do @(posedge clk); while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
		case (idx)
			lsq_pkg::REG_NUM_ROWS: begin
				frame_rows = value & ((1 << FIELD_W) - 1);
				clear_frame_progress();
			end
			lsq_pkg::REG_NUM_COLS: begin
				frame_cols = value & ((1 << FIELD_W) - 1);
				clear_frame_progress();
			end
			default: ;
		endcase
	endtask

	task automatic set_size(input int unsigned rows, input int unsigned cols);
		settle();
		write_reg(lsq_pkg::REG_NUM_ROWS, rows, 1'b0);
		write_reg(lsq_pkg::REG_NUM_COLS, cols, 1'b1);
	endtask

	task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic test_basic_frames();
		set_size(1, 1);
		send_cell(1'b0);
		send_cell(1'b1);
		// zero sizes act as one
		set_size(0, 0);
		send_cell(1'b1);
		set_size(3, 3);
		repeat (9) send_cell(1'b1);
		// equal squares later on do not replace the first
		set_size(2, 2);
		send_cell(1'b1);
		send_cell(1'b0);
		send_cell(1'b0);
		send_cell(1'b1);
		set_size(2, 3);
		repeat (2) begin
			send_cell(1'b0);
			send_cell(1'b1);
			send_cell(1'b1);
		end
	endtask

	task automatic test_restart_on_write();
		set_size(3, 4);
		send_frame(5, 50);
		settle();
		// unused indexes leave the frame running
		write_reg(REG_SPARE_HIGH, $urandom, 1'b0);
		write_reg(REG_SPARE_LOW, $urandom, 1'b1);
		send_frame(7, 80);
		send_frame(6, 70);
		settle();
		write_reg(lsq_pkg::REG_NUM_COLS, 4, 1'b1);
		send_frame(12, 80);
	endtask

	// large frames are only started here, the next size write cuts them short
	task automatic test_size_limits();
		set_size(4096, 0);
		send_frame(PARTIAL_ITEMS, 95);
		// oversize acts as the maximum
		set_size(8191, 1);
		send_frame(PARTIAL_ITEMS, 95);
		set_size(2, 8191);
		send_frame(PARTIAL_ITEMS, 90);
	endtask

	task automatic test_back_pressure();
		set_size(1, 1);
		steady = 1'b1;
		hold_long = 1'b1;
		send_frame(60, 50);
		steady = 1'b0;
		settle();
	endtask

	task automatic test_random_frames();
		int sent;
		int unsigned rows;
		int unsigned cols;
		int unsigned cells;
		int unsigned pct;
		int unsigned cut;
		sent = 0;
		rows = 4;
		cols = 4;
		set_size(rows, cols);
		while (sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(4) == 0);
			if ($urandom_range(2) != 0) begin
				if ($urandom_range(3) == 0) begin
					rows = $urandom_range(12, 1);
					cols = $urandom_range(12, 1);
				end else begin
					rows = $urandom_range(6, 1);
					cols = $urandom_range(6, 1);
				end
				set_size(rows, cols);
			end
			cells = rows * cols;
			pct = $urandom_range(100, 40);
			// broken frame, cut short by a size write
			if (cells > 1 && $urandom_range(9) == 0) begin
				cut = $urandom_range(cells - 1, 1);
				send_frame(cut, pct);
				sent += cut;
				settle();
				write_reg(lsq_pkg::REG_NUM_ROWS, rows, 1'b1);
			end
			send_frame(cells, pct);
			sent += cells;
		end
		steady = 1'b0;
	endtask

	initial begin : result_sink
		int hold;
		square_t want;
		forever begin
			if (hold_long) begin
				hold = LONG_HOLD;
				hold_long = 1'b0;
			end else begin
				hold = steady ? 0 : $urandom_range(13);
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			if (expected_squares.size() == 0) begin
				$display("%0t: unexpected item, expected none actual side %0d row %0d col %0d",
					$time, side_length, top_row, left_col);
				errors++;
			end else begin
				want = expected_squares.pop_front();
				compare_field("side_length", want.side, side_length);
				compare_field("top_row", want.row, top_row);
				compare_field("left_col", want.col, left_col);
			end
		end
	end

	always @(posedge clk) begin
		if ((cell_valid && !cell_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_basic_frames();
		test_restart_on_write();
		test_size_limits();
		test_back_pressure();
		test_random_frames();
		settle();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
